/* hdl/fsn_pkg.sv */
// shared types, constants and helper functions of the fractal simplex noise sampler
package fsn_pkg;

    localparam int unsigned TABLE_AW = 8;
    localparam logic [4:0] MAX_OCTAVES = 5'd16;

    // request function codes
    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    // configuration register indexes
    localparam logic [7:0] CFG_OCTAVE_COUNT = 8'd0;
    localparam logic [7:0] CFG_PERSISTENCE  = 8'd1;
    localparam logic [7:0] CFG_BASE_SCALE   = 8'd2;
    localparam logic [7:0] CFG_NORM_GAIN    = 8'd3;

    localparam logic [4:0]  RST_OCTAVE_COUNT = 5'd4;
    localparam logic [15:0] RST_PERSISTENCE  = 16'd16384;
    localparam logic [31:0] RST_BASE_SCALE   = 32'd131072;
    localparam logic [31:0] RST_NORM_GAIN    = 32'd34953;

    // 15000.0 in Q16.16
    localparam logic signed [32:0] OFFSET_Q16 = 33'sd983040000;
    // skew and unskew factors in Q0.32
    localparam logic [31:0] SKEW_F2   = 32'd1572067139;
    localparam logic [29:0] UNSKEW_G2 = 30'd907633386;
    // corner offsets in Q.16
    localparam logic signed [18:0] ONE_Q16   = 19'sd65536;
    localparam logic signed [18:0] G2_Q16    = 19'sd13849;
    localparam logic signed [18:0] G2X2_Q16  = 19'sd27698;
    localparam logic [37:0]        HALF_Q32  = 38'd2147483648;
    localparam logic [31:0]        WEIGHT_0  = 32'd32768;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MULT,
        ST_POINT,
        ST_SKEWMUL,
        ST_SKEW,
        ST_O_CELL,
        ST_O_UNSKEW,
        ST_O_OFFS,
        ST_O_HASH,
        ST_O_HASH2,
        ST_O_FALL,
        ST_O_DOT,
        ST_O_SUM,
        ST_O_ACC,
        ST_FMUL,
        ST_FOUT
    } t_state;

    typedef struct packed {
        logic                we;
        logic [TABLE_AW-1:0] addr_a;
        logic [7:0]          wdata;
        logic [TABLE_AW-1:0] addr_b;
    } t_ram_req;

    // gradient dot product, gradient picked by hash mod 12
    function automatic logic signed [19:0] grad_dot(input logic [7:0] h,
                                                   input logic signed [18:0] ax,
                                                   input logic signed [18:0] ay);
        logic [15:0]        prod;
        logic [4:0]         q;
        logic [7:0]         r;
        logic signed [19:0] x;
        logic signed [19:0] y;
        logic signed [19:0] d;
        prod = 16'(h) * 16'd171;
        q    = prod[15:11];
        r    = h - {q, 3'b000} - {1'b0, q, 2'b00};
        if (r >= 8'd12) begin
            r = r - 8'd12;
        end
        x = 20'(ax);
        y = 20'(ay);
        unique case (r[3:0])
            4'd0:    d = x + y;
            4'd1:    d = y - x;
            4'd2:    d = x - y;
            4'd3:    d = -x - y;
            4'd4:    d = x;
            4'd5:    d = -x;
            4'd6:    d = x;
            4'd7:    d = -x;
            4'd8:    d = y;
            4'd9:    d = -y;
            4'd10:   d = y;
            4'd11:   d = -y;
            default: d = '0;
        endcase
        return d;
    endfunction

endpackage

/* hdl/fsn_perm_ram.sv */
// permutation table memory, one read/write port and one read port, registered reads
module fsn_perm_ram (
    input  logic                i_clk,
    input  fsn_pkg::t_ram_req   i_req,
    output logic [7:0]          o_rdata_a,
    output logic [7:0]          o_rdata_b
);

    logic [7:0] r_mem [2**fsn_pkg::TABLE_AW];
    logic [7:0] r_rdata_a;
    logic [7:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr_a] <= i_req.wdata;
        end
        r_rdata_a <= r_mem[i_req.addr_a];
        r_rdata_b <= r_mem[i_req.addr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

/* hdl/fsn_corner.sv */
// one simplex corner: falloff (0.5 - r^2)^4 times gradient dot, four register stages
module fsn_corner (
    input  logic               i_clk,
    input  logic signed [18:0] i_ax,
    input  logic signed [18:0] i_ay,
    input  logic [7:0]         i_hash,
    output logic signed [52:0] o_contrib
);

    logic signed [37:0] sq_x;
    logic signed [37:0] sq_y;
    logic [37:0]        r_sq;
    logic               live;
    logic [31:0]        t;
    logic [63:0]        tt;
    logic [31:0]        r_t2;
    logic [63:0]        t4p;
    logic [31:0]        r_t4;
    logic signed [19:0] dot;
    logic signed [52:0] r_contrib;

    assign sq_x = i_ax * i_ax;
    assign sq_y = i_ay * i_ay;

    // outside the falloff radius the corner gives nothing
    assign live = (r_sq <= fsn_pkg::HALF_Q32);
    assign t    = 32'(fsn_pkg::HALF_Q32 - r_sq);
    assign tt   = 64'(t) * 64'(t);
    assign t4p  = 64'(r_t2) * 64'(r_t2);
    assign dot  = fsn_pkg::grad_dot(i_hash, i_ax, i_ay);

    always_ff @(posedge i_clk) begin
        r_sq      <= $unsigned(sq_x) + $unsigned(sq_y);
        r_t2      <= live ? tt[63:32] : 32'd0;
        r_t4      <= t4p[63:32];
        r_contrib <= $signed({1'b0, r_t4}) * dot;
    end

    assign o_contrib = r_contrib;

endmodule

/* hdl/fractal_simplex_noise_2d.sv */
// top level of the fractal 2d simplex noise sampler
// Fractal 2D simplex noise sampler. A request with func = 0 writes one entry of the
// 256-entry permutation table and gives no result; the table holds garbage until
// every entry used has been written. A request with func = 1 samples noise at a
// signed Q16.16 point and gives one result: noise_value in signed Q16.16, saturated, with
// saturated set when it was clipped. Octaves run one after another through one shared
// simplex datapath; the permutation table has two read ports, so the three hash lookups
// of an octave take three read rounds. A sample runs n octaves, n being octave_count
// limited to 16 (4 octaves at the reset value). A new request is taken once the
// previous sample has put its result in the output register, and the result waits
// there until taken. Config writes are always taken and should only be made while
// no sample is in flight.
module fractal_simplex_noise_2d (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_func,
    input  logic [7:0]         i_table_index,
    input  logic [7:0]         i_table_value,
    input  logic signed [31:0] i_x_coord,
    input  logic signed [31:0] i_y_coord,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_noise_value,
    output logic               o_saturated,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [7:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    fsn_pkg::t_state   r_state;
    fsn_pkg::t_state   n_state;
    fsn_pkg::t_ram_req ram_req;
    logic [7:0]        rd_a;
    logic [7:0]        rd_b;

    // configuration registers
    logic [4:0]  r_octave_count;
    logic [15:0] r_persistence;
    logic [31:0] r_base_scale;
    logic [31:0] r_norm_gain;

    logic        in_accept;
    logic [4:0]  oct_lim;
    logic        oct_last;
    logic        out_load;

    // point setup
    logic signed [32:0] r_xs, r_ys;
    logic [47:0]        r_ppl_x, r_ppl_y;
    logic signed [48:0] r_pph_x, r_pph_y;
    logic [64:0]        full_x, full_y;
    logic [40:0]        r_px, r_py;
    logic [41:0]        sxy;
    logic [34:0]        r_mh;
    logic [52:0]        r_ml;
    logic [55:0]        mix;
    logic [55:0]        r_skx, r_sky;

    // octave datapath
    logic [3:0]         r_oct;
    logic [55:0]        sh_x, sh_y;
    logic [7:0]         r_ii, r_jj;
    logic [15:0]        r_fx, r_fy;
    logic [46:0]        gprod;
    logic [14:0]        r_g;
    logic               r_i1;
    logic signed [18:0] dx, dy;
    logic signed [18:0] r_ax0, r_ay0, r_ax1, r_ay1, r_ax2, r_ay2;
    logic [7:0]         r_pj0, r_pj1;
    logic [7:0]         r_h1, r_h2, r_h3;
    logic signed [52:0] c0, c1, c2;
    logic signed [54:0] csum;
    logic signed [61:0] c70;
    logic signed [29:0] noise;
    logic signed [62:0] r_prod;
    logic signed [63:0] r_acc;
    logic [31:0]        r_w;
    logic [47:0]        wprod;
    logic [32:0]        wnext;

    // output scaling
    logic [63:0]        r_flo;
    logic signed [64:0] r_fhi;
    logic signed [96:0] total;
    logic signed [65:0] q;
    logic               pos_ovf, neg_ovf;
    logic               r_out_valid;
    logic signed [31:0] r_noise;
    logic               r_sat;

    assign in_accept   = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    // octave count clamps at the octave limit
    assign oct_lim  = (r_octave_count > fsn_pkg::MAX_OCTAVES) ? fsn_pkg::MAX_OCTAVES
                                                              : r_octave_count;
    assign oct_last = ({1'b0, r_oct} == (oct_lim - 5'd1));
    assign out_load = (r_state == fsn_pkg::ST_FOUT) && (!r_out_valid || i_out_ready);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fsn_pkg::ST_IDLE: begin
                if (in_accept && (i_func == fsn_pkg::FUNC_SAMPLE)) begin
                    n_state = fsn_pkg::ST_MULT;
                end
            end
            fsn_pkg::ST_MULT:     n_state = fsn_pkg::ST_POINT;
            fsn_pkg::ST_POINT:    n_state = fsn_pkg::ST_SKEWMUL;
            fsn_pkg::ST_SKEWMUL:  n_state = fsn_pkg::ST_SKEW;
            fsn_pkg::ST_SKEW: begin
                n_state = (oct_lim == 5'd0) ? fsn_pkg::ST_FMUL : fsn_pkg::ST_O_CELL;
            end
            fsn_pkg::ST_O_CELL:   n_state = fsn_pkg::ST_O_UNSKEW;
            fsn_pkg::ST_O_UNSKEW: n_state = fsn_pkg::ST_O_OFFS;
            fsn_pkg::ST_O_OFFS:   n_state = fsn_pkg::ST_O_HASH;
            fsn_pkg::ST_O_HASH:   n_state = fsn_pkg::ST_O_HASH2;
            fsn_pkg::ST_O_HASH2:  n_state = fsn_pkg::ST_O_FALL;
            fsn_pkg::ST_O_FALL:   n_state = fsn_pkg::ST_O_DOT;
            fsn_pkg::ST_O_DOT:    n_state = fsn_pkg::ST_O_SUM;
            fsn_pkg::ST_O_SUM:    n_state = fsn_pkg::ST_O_ACC;
            fsn_pkg::ST_O_ACC: begin
                n_state = oct_last ? fsn_pkg::ST_FMUL : fsn_pkg::ST_O_CELL;
            end
            fsn_pkg::ST_FMUL:     n_state = fsn_pkg::ST_FOUT;
            fsn_pkg::ST_FOUT: begin
                if (out_load) begin
                    n_state = fsn_pkg::ST_IDLE;
                end
            end
            default:              n_state = fsn_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer: request ready and table accesses
    always_comb begin
        o_in_ready     = 1'b0;
        ram_req.we     = 1'b0;
        ram_req.addr_a = '0;
        ram_req.wdata  = i_table_value;
        ram_req.addr_b = '0;
        unique case (r_state)
            fsn_pkg::ST_IDLE: begin
                o_in_ready     = 1'b1;
                ram_req.we     = i_in_valid && (i_func == fsn_pkg::FUNC_LOAD);
                ram_req.addr_a = i_table_index;
            end
            fsn_pkg::ST_O_UNSKEW: begin
                // first hash round: perm[jj] and perm[jj + 1]
                ram_req.addr_a = r_jj;
                ram_req.addr_b = r_jj + 8'd1;
            end
            fsn_pkg::ST_O_OFFS: begin
                // second round: first and last corner
                ram_req.addr_a = r_ii + rd_a;
                ram_req.addr_b = r_ii + 8'd1 + rd_b;
            end
            fsn_pkg::ST_O_HASH: begin
                // third round: middle corner, picked by the triangle
                ram_req.addr_a = r_i1 ? (r_ii + 8'd1 + r_pj0) : (r_ii + r_pj1);
            end
            default: begin
                ram_req.we = 1'b0;
            end
        endcase
    end

    fsn_perm_ram u_perm_ram (
        .i_clk     (i_clk),
        .i_req     (ram_req),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= fsn_pkg::ST_IDLE;
            r_octave_count <= fsn_pkg::RST_OCTAVE_COUNT;
            r_persistence  <= fsn_pkg::RST_PERSISTENCE;
            r_base_scale   <= fsn_pkg::RST_BASE_SCALE;
            r_norm_gain    <= fsn_pkg::RST_NORM_GAIN;
            r_out_valid    <= 1'b0;
            r_oct          <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    fsn_pkg::CFG_OCTAVE_COUNT: r_octave_count <= i_cfg_data[4:0];
                    fsn_pkg::CFG_PERSISTENCE:  r_persistence  <= i_cfg_data[15:0];
                    fsn_pkg::CFG_BASE_SCALE:   r_base_scale   <= i_cfg_data;
                    fsn_pkg::CFG_NORM_GAIN:    r_norm_gain    <= i_cfg_data;
                    default:                   ;
                endcase
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == fsn_pkg::ST_SKEW) begin
                r_oct <= '0;
            end else if (r_state == fsn_pkg::ST_O_ACC) begin
                r_oct <= r_oct + 4'd1;
            end
        end
    end

    // point setup: offset, scale by base_scale in two partial products, skew
    assign full_x = {r_pph_x, 16'b0} + {17'b0, r_ppl_x};
    assign full_y = {r_pph_y, 16'b0} + {17'b0, r_ppl_y};
    assign sxy    = {r_px[40], r_px} + {r_py[40], r_py};
    // skew sum times F2, kept modulo 2^56; later octaves are this value shifted left
    assign mix    = {r_mh, 21'b0} + {3'b0, r_ml};

    // per-octave cell, fraction and unskew
    assign sh_x  = r_skx << r_oct;
    assign sh_y  = r_sky << r_oct;
    assign gprod = 47'({1'b0, r_fx} + {1'b0, r_fy}) * 47'(fsn_pkg::UNSKEW_G2);
    assign dx    = $signed({3'b0, r_fx}) - $signed({4'b0, r_g});
    assign dy    = $signed({3'b0, r_fy}) - $signed({4'b0, r_g});

    fsn_corner u_corner0 (
        .i_clk(i_clk), .i_ax(r_ax0), .i_ay(r_ay0), .i_hash(r_h1), .o_contrib(c0)
    );
    fsn_corner u_corner1 (
        .i_clk(i_clk), .i_ax(r_ax1), .i_ay(r_ay1), .i_hash(r_h2), .o_contrib(c1)
    );
    fsn_corner u_corner2 (
        .i_clk(i_clk), .i_ax(r_ax2), .i_ay(r_ay2), .i_hash(r_h3), .o_contrib(c2)
    );

    // octave noise = floor(70 * sum / 2^32)
    assign csum  = 55'(c0) + 55'(c1) + 55'(c2);
    assign c70   = (62'(csum) <<< 6) + (62'(csum) <<< 2) + (62'(csum) <<< 1);
    assign noise = c70[61:32];

    // next weight, saturating at 32 bits
    assign wprod = 48'(r_w) * 48'(r_persistence);
    assign wnext = wprod[47:15];

    // final gain, floor of acc * norm_gain / 2^31
    assign total   = $signed({r_fhi, 32'b0}) + $signed({33'b0, r_flo});
    assign q       = total[96:31];
    assign pos_ovf = !q[65] && (|q[64:31]);
    assign neg_ovf = q[65] && !(&q[64:31]);

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            fsn_pkg::ST_IDLE: begin
                r_xs <= $signed({i_x_coord[31], i_x_coord}) + fsn_pkg::OFFSET_Q16;
                r_ys <= $signed({i_y_coord[31], i_y_coord}) + fsn_pkg::OFFSET_Q16;
            end
            fsn_pkg::ST_MULT: begin
                r_ppl_x <= 48'(r_xs[15:0]) * 48'(r_base_scale);
                r_ppl_y <= 48'(r_ys[15:0]) * 48'(r_base_scale);
                r_pph_x <= 49'($signed(r_xs[32:16])) * 49'($signed({1'b0, r_base_scale}));
                r_pph_y <= 49'($signed(r_ys[32:16])) * 49'($signed({1'b0, r_base_scale}));
            end
            fsn_pkg::ST_POINT: begin
                r_px <= full_x[64:24];
                r_py <= full_y[64:24];
            end
            fsn_pkg::ST_SKEWMUL: begin
                // upper part of the skew sum carries its sign
                r_mh <= 35'($signed(sxy[41:21])) * 35'(fsn_pkg::SKEW_F2);
                r_ml <= 53'(sxy[20:0]) * 53'(fsn_pkg::SKEW_F2);
            end
            fsn_pkg::ST_SKEW: begin
                r_skx <= {r_px[23:0], 32'b0} + mix;
                r_sky <= {r_py[23:0], 32'b0} + mix;
                r_acc <= '0;
                r_w   <= fsn_pkg::WEIGHT_0;
            end
            fsn_pkg::ST_O_CELL: begin
                r_ii <= sh_x[55:48];
                r_jj <= sh_y[55:48];
                r_fx <= sh_x[47:32];
                r_fy <= sh_y[47:32];
            end
            fsn_pkg::ST_O_UNSKEW: begin
                r_g  <= gprod[46:32];
                r_i1 <= (r_fx > r_fy);
            end
            fsn_pkg::ST_O_OFFS: begin
                r_pj0 <= rd_a;
                r_pj1 <= rd_b;
                r_ax0 <= dx;
                r_ay0 <= dy;
                r_ax1 <= (r_i1 ? dx - fsn_pkg::ONE_Q16 : dx) + fsn_pkg::G2_Q16;
                r_ay1 <= (r_i1 ? dy : dy - fsn_pkg::ONE_Q16) + fsn_pkg::G2_Q16;
                r_ax2 <= dx - fsn_pkg::ONE_Q16 + fsn_pkg::G2X2_Q16;
                r_ay2 <= dy - fsn_pkg::ONE_Q16 + fsn_pkg::G2X2_Q16;
            end
            fsn_pkg::ST_O_HASH: begin
                r_h1 <= rd_a;
                r_h3 <= rd_b;
            end
            fsn_pkg::ST_O_HASH2: begin
                r_h2 <= rd_a;
            end
            fsn_pkg::ST_O_SUM: begin
                r_prod <= 63'(noise) * 63'($signed({1'b0, r_w}));
            end
            fsn_pkg::ST_O_ACC: begin
                r_acc <= r_acc + 64'(r_prod);
                r_w   <= wnext[32] ? 32'hFFFF_FFFF : wnext[31:0];
            end
            fsn_pkg::ST_FMUL: begin
                r_flo <= 64'(r_acc[31:0]) * 64'(r_norm_gain);
                r_fhi <= 65'($signed(r_acc[63:32])) * 65'($signed({1'b0, r_norm_gain}));
            end
            fsn_pkg::ST_FOUT: begin
                if (out_load) begin
                    r_noise <= pos_ovf ? 32'sh7FFF_FFFF :
                               neg_ovf ? 32'sh8000_0000 : q[31:0];
                    r_sat   <= pos_ovf || neg_ovf;
                end
            end
            default: begin
                r_h2 <= r_h2;
            end
        endcase
    end

    assign o_out_valid   = r_out_valid;
    assign o_noise_value = r_noise;
    assign o_saturated   = r_sat;

    // a clipped result sits at one of the two range ends
    a_sat_extreme: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_saturated) |->
            (o_noise_value == 32'sh7FFF_FFFF || o_noise_value == 32'sh8000_0000))
        else $error("saturated result not at range end");

    // the octave counter stays below the clamped octave count
    a_oct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fsn_pkg::ST_O_ACC) |-> ({1'b0, r_oct} < oct_lim))
        else $error("octave counter out of range");

    // table writes happen only between samples
    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_req.we |-> (r_state == fsn_pkg::ST_IDLE))
        else $error("table write during a sample");

    // a finished sample waits while the previous result is not taken
    a_out_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fsn_pkg::ST_FOUT && o_out_valid && !i_out_ready)
            |=> (r_state == fsn_pkg::ST_FOUT))
        else $error("result overwritten before taken");

endmodule

/* sim/tb_fractal_simplex_noise_2d.sv */
// self-checking testbench of the fractal 2d simplex noise sampler
module tb_fractal_simplex_noise_2d;
    timeunit 1ns;
    timeprecision 1ps;

    // generous limit: ~1500 requests plus stalls, taken several times over
    localparam int unsigned CYCLE_LIMIT = 3_000_000;
    // covers the longest sample with margin
    localparam int unsigned DRAIN_CYCLES = 200;

    typedef struct {
        logic signed [31:0] value;
        logic               sat;
    } t_noise_result;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic               i_func;
    logic [7:0]         i_table_index;
    logic [7:0]         i_table_value;
    logic signed [31:0] i_x_coord;
    logic signed [31:0] i_y_coord;
    logic               o_out_valid;
    logic               i_out_ready;
    logic signed [31:0] o_noise_value;
    logic               o_saturated;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [7:0]         i_cfg_index;
    logic [31:0]        i_cfg_data;

    // shadow copy of the block state and registers
    logic [7:0]  perm_shadow [256];
    logic [4:0]  octave_count;
    logic [15:0] persistence;
    logic [31:0] base_scale;
    logic [31:0] norm_gain;

    t_noise_result expected_noise [$];
    int unsigned   error_count;
    int unsigned   cycle_count;
    int unsigned   send_idle_pct;
    int unsigned   recv_stall_pct;
    int unsigned   hold_off_cycles;

    fractal_simplex_noise_2d dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_func        (i_func),
        .i_table_index (i_table_index),
        .i_table_value (i_table_value),
        .i_x_coord     (i_x_coord),
        .i_y_coord     (i_y_coord),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_noise_value (o_noise_value),
        .o_saturated   (o_saturated),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // noise predictor
    // ---------------------------------------------------------------

    // floor(v * s / 2^24), wrapping in 64 bits
    function automatic logic [63:0] scale_point(longint v, logic [31:0] s);
        logic [63:0] m;
        if (v >= 0) begin
            return (64'(v) * 64'(s)) >> 24;
        end
        m = 64'(-v) * 64'(s);
        return 64'd0 - ((m + 64'hFF_FFFF) >> 24);
    endfunction

    function automatic logic [7:0] perm_hash(logic [7:0] a, logic [7:0] b);
        logic [7:0] mix;
        mix = a + perm_shadow[b];
        return perm_shadow[mix];
    endfunction

    // falloff-weighted gradient contribution of one corner
    function automatic longint corner_term(longint ax, longint ay, logic [7:0] h);
        longint      t;
        longint      d;
        logic [63:0] t2;
        logic [63:0] t4;
        t = 64'sh8000_0000 - (ax * ax + ay * ay);
        if (t < 0) begin
            return 0;
        end
        t2 = (64'(t) * 64'(t)) >> 32;
        t4 = (t2 * t2) >> 32;
        case (h % 12)
            0:       d = ax + ay;
            1:       d = ay - ax;
            2:       d = ax - ay;
            3:       d = -ax - ay;
            4, 6:    d = ax;
            5, 7:    d = -ax;
            8, 10:   d = ay;
            default: d = -ay;
        endcase
        return longint'(t4) * d;
    endfunction

    // one simplex octave at a wrapped Q.16 point, result Q.16
    function automatic longint octave_noise(logic [63:0] px, logic [63:0] py);
        logic [63:0] mix;
        logic [63:0] sx;
        logic [63:0] sy;
        logic [7:0]  ci;
        logic [7:0]  cj;
        longint      fx;
        longint      fy;
        longint      g;
        longint      dx;
        longint      dy;
        longint      lo_x;
        longint      lo_y;
        longint      sum;
        mix = (px + py) * 64'd1572067139;
        sx  = (px << 32) + mix;
        sy  = (py << 32) + mix;
        ci  = sx[55:48];
        cj  = sy[55:48];
        fx  = longint'(sx[47:32]);
        fy  = longint'(sy[47:32]);
        g   = longint'((64'(fx + fy) * 64'd907633386) >> 32);
        dx  = fx - g;
        dy  = fy - g;
        // lower triangle steps in x first
        lo_x = (fx > fy) ? 1 : 0;
        lo_y = 1 - lo_x;
        sum = corner_term(dx, dy, perm_hash(ci, cj));
        sum += corner_term(dx - lo_x * 65536 + 13849, dy - lo_y * 65536 + 13849,
                           perm_hash(ci + 8'(lo_x), cj + 8'(lo_y)));
        sum += corner_term(dx - 65536 + 27698, dy - 65536 + 27698,
                           perm_hash(ci + 8'd1, cj + 8'd1));
        return (sum * 70) >>> 32;
    endfunction

    function automatic t_noise_result fractal_noise(logic signed [31:0] x,
                                                    logic signed [31:0] y);
        t_noise_result res;
        logic [63:0]   px;
        logic [63:0]   py;
        logic [63:0]   w;
        logic [63:0]   m;
        logic [63:0]   plo;
        logic [63:0]   phi;
        logic [63:0]   r;
        longint        acc;
        int unsigned   n;
        logic          neg;
        px  = scale_point(longint'(x) + 64'sd983040000, base_scale);
        py  = scale_point(longint'(y) + 64'sd983040000, base_scale);
        n   = (octave_count > 16) ? 16 : octave_count;
        w   = 64'd32768;
        acc = 0;
        for (int unsigned i = 0; i < n; i++) begin
            acc += octave_noise(px << i, py << i) * longint'(w);
            w = (w * 64'(persistence)) >> 15;
            if (w > 64'hFFFF_FFFF) begin
                w = 64'hFFFF_FFFF;
            end
        end
        neg = acc < 0;
        m   = neg ? 64'(-acc) : 64'(acc);
        plo = 64'(m[31:0]) * 64'(norm_gain);
        phi = (m >> 32) * 64'(norm_gain);
        r   = 2 * phi + (plo >> 31);
        if (neg && plo[30:0] != 0) begin
            r += 1;
        end
        res.sat = 1'b0;
        if (!neg) begin
            if (r > 64'h7FFF_FFFF) begin
                res.sat   = 1'b1;
                res.value = 32'sh7FFF_FFFF;
            end else begin
                res.value = r[31:0];
            end
        end else begin
            if (r > 64'h8000_0000) begin
                res.sat   = 1'b1;
                res.value = 32'sh8000_0000;
            end else begin
                res.value = -r[31:0];
            end
        end
        return res;
    endfunction

    // ---------------------------------------------------------------
    // shared drivers
    // ---------------------------------------------------------------

    // send one request; valid stays high into the next call unless it idles
    task automatic send_request(logic func, logic [7:0] idx, logic [7:0] val,
                                logic signed [31:0] x, logic signed [31:0] y);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_func        <= func;
        i_table_index <= idx;
        i_table_value <= val;
        i_x_coord     <= x;
        i_y_coord     <= y;
        do @(posedge i_clk); while (!o_in_ready);
        // request accepted at this edge
        if (func == fsn_pkg::FUNC_LOAD) begin
            perm_shadow[idx] = val;
        end else begin
            expected_noise.push_back(fractal_noise(x, y));
        end
    endtask

    task automatic send_sample(logic signed [31:0] x, logic signed [31:0] y);
        send_request(fsn_pkg::FUNC_SAMPLE, 8'($urandom), 8'($urandom), x, y);
    endtask

    // let every sample in flight finish before touching registers
    task automatic drain();
        i_in_valid <= 1'b0;
        wait (expected_noise.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // one register write, with valid dropped again after it
    task automatic write_reg(logic [7:0] idx, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            fsn_pkg::CFG_OCTAVE_COUNT: octave_count = data[4:0];
            fsn_pkg::CFG_PERSISTENCE:  persistence  = data[15:0];
            fsn_pkg::CFG_BASE_SCALE:   base_scale   = data;
            fsn_pkg::CFG_NORM_GAIN:    norm_gain    = data;
            default:                   ; // unknown index is ignored
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_config(logic [31:0] oct, logic [31:0] pers,
                              logic [31:0] scale, logic [31:0] gain);
        drain();
        write_reg(fsn_pkg::CFG_OCTAVE_COUNT, oct);
        write_reg(fsn_pkg::CFG_PERSISTENCE, pers);
        write_reg(fsn_pkg::CFG_BASE_SCALE, scale);
        write_reg(fsn_pkg::CFG_NORM_GAIN, gain);
    endtask

    // mostly points near the noise origin, sometimes anywhere
    function automatic logic signed [31:0] rand_coord();
        if ($urandom_range(0, 3) == 0) begin
            return $urandom;
        end
        return -32'sd983040000 + $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
    endfunction

    // ---------------------------------------------------------------
    // result checker and receiver stalls
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_noise_result want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_noise.size() == 0) begin
                    $display("%0t: unexpected result noise=%h sat=%b",
                             $time, o_noise_value, o_saturated);
                    error_count++;
                end else begin
                    want = expected_noise.pop_front();
                    if (o_noise_value !== want.value) begin
                        $display("%0t: noise_value expected %h actual %h",
                                 $time, want.value, o_noise_value);
                        error_count++;
                    end
                    if (o_saturated !== want.sat) begin
                        $display("%0t: saturated expected %b actual %b",
                                 $time, want.sat, o_saturated);
                        error_count++;
                    end
                end
            end
            // a long hold-off counted here, else random stalls
            if (hold_off_cycles > 0) begin
                hold_off_cycles <= hold_off_cycles - 1;
                i_out_ready     <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // every table entry is written before the first sample
    task automatic test_table_fill();
        for (int i = 0; i < 256; i++) begin
            send_request(fsn_pkg::FUNC_LOAD, 8'(i), 8'($urandom), $urandom, $urandom);
        end
    endtask

    // field extremes at the reset configuration
    task automatic test_directed_points();
        send_sample(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_sample(32'sh8000_0000, 32'sh8000_0000);
        send_sample(32'sh7FFF_FFFF, 32'sh8000_0000);
        send_sample(32'sh8000_0000, 32'sh7FFF_FFFF);
        send_sample(32'sd0, 32'sd0);
        send_sample(-32'sd1, -32'sd1);
        // offset point lands on the origin
        send_sample(-32'sd983040000, -32'sd983040000);
        send_sample(-32'sd983040000, 32'sd0);
        send_sample(32'sh5555_5555, 32'shAAAA_AAAA);
        send_sample(32'shAAAA_AAAA, 32'sh5555_5555);
        // reload an entry mid-stream, index and value at their extremes
        send_request(fsn_pkg::FUNC_LOAD, 8'hFF, 8'h00, 32'sd0, 32'sd0);
        send_request(fsn_pkg::FUNC_LOAD, 8'h00, 8'hFF, 32'sd0, 32'sd0);
        send_sample(32'sd12345, -32'sd54321);
    endtask

    // register extremes, zero and too many octaves, unknown index
    task automatic test_config_extremes();
        set_config(0, 16384, 131072, 34953);
        repeat (3) send_sample(rand_coord(), rand_coord());
        set_config(31, 65535, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        repeat (4) send_sample(rand_coord(), rand_coord());
        set_config(16, 0, 0, 0);
        repeat (3) send_sample(rand_coord(), rand_coord());
        set_config(1, 65535, 32'h0100_0000, 32'h0001_0000);
        repeat (3) send_sample(rand_coord(), rand_coord());
        set_config(16, 65535, 32'h0000_0001, 32'h7FFF_FFFF);
        repeat (3) send_sample(rand_coord(), rand_coord());
        drain();
        write_reg(8'd4, 32'hFFFF_FFFF);
        write_reg(8'hFF, 32'h0);
        set_config(4, 16384, 131072, 32'h0100_0000);
        repeat (4) send_sample(rand_coord(), rand_coord());
    endtask

    // receiver holds off while requests keep coming
    task automatic test_output_hold_off();
        set_config(2, 20000, 131072, 34953);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 600;
        repeat (20) send_sample(rand_coord(), rand_coord());
    endtask

    // random phases with changing idle patterns and configurations
    task automatic test_random_traffic();
        int unsigned send_pcts [4] = '{0, 47, 0, 19};
        int unsigned recv_pcts [4] = '{0, 0, 47, 19};
        for (int ph = 0; ph < 4; ph++) begin
            set_config(($urandom_range(0, 9) == 0) ? 16 : $urandom_range(1, 6),
                       $urandom_range(0, 65535),
                       ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h0200_0000),
                       ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h0004_0000));
            send_idle_pct  = send_pcts[ph];
            recv_stall_pct = recv_pcts[ph];
            repeat (300) begin
                if ($urandom_range(0, 99) < 12) begin
                    send_request(fsn_pkg::FUNC_LOAD, 8'($urandom), 8'($urandom),
                                 $urandom, $urandom);
                end else begin
                    send_sample(rand_coord(), rand_coord());
                end
            end
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_func          = fsn_pkg::FUNC_LOAD;
        i_table_index   = '0;
        i_table_value   = '0;
        i_x_coord       = '0;
        i_y_coord       = '0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        error_count     = 0;
        cycle_count     = 0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_off_cycles = 0;
        octave_count    = fsn_pkg::RST_OCTAVE_COUNT;
        persistence     = fsn_pkg::RST_PERSISTENCE;
        base_scale      = fsn_pkg::RST_BASE_SCALE;
        norm_gain       = fsn_pkg::RST_NORM_GAIN;
        foreach (perm_shadow[i]) perm_shadow[i] = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_table_fill();
        test_directed_points();
        test_config_extremes();
        test_output_hold_off();
        test_random_traffic();

        drain();
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
